// ----- design/tpts_pkg.sv -----
`default_nettype none
package tpts_pkg;

  typedef enum logic [1:0] {
    REQ_DEFER_TIMED = 2'd0,
    REQ_DEFER_NOW   = 2'd1,
    REQ_CANCEL      = 2'd2,
    REQ_RUN         = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_DEFER_ACK  = 2'd0,
    KIND_CANCEL_ACK = 2'd1,
    KIND_DISPATCH   = 2'd2,
    KIND_SUMMARY    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_LAST,
    S_POP_GET,
    S_DN_CHK,
    S_DN_RR,
    S_DN_CMP,
    S_CAN_RD,
    S_CAN_WR,
    S_RUN_T,
    S_RUN_MV,
    S_RUN_P,
    S_RUN_EM,
    S_SUM,
    S_ACK
  } state_t;

  localparam int TAG_W = 49;
  localparam int ENTRY_W = 97;
  localparam logic [5:0] MAX_DISPATCH = 6'd32;
  localparam logic [5:0] DROP_SAT = 6'd63;

  typedef struct packed {
    logic        live;
    logic [15:0] prio;
    logic [15:0] ticket;
    logic [15:0] id;
  } tag_t;

  typedef struct packed {
    logic [47:0] due;
    tag_t        tag;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] id;
    logic        accepted;
    logic [5:0]  dispatched;
    logic [5:0]  dropped;
    logic        next_valid;
    logic [47:0] next_time;
  } result_t;

  // which: 0 orders by due time, 1 by priority; ties go to the older ticket
  function automatic logic entry_less(logic which, entry_t a, entry_t b);
    logic [15:0] d;
    logic        tl;
    d = a.tag.ticket - b.tag.ticket;
    tl = (d != 16'd0) && d[15];
    if (!which) begin
      return (a.due < b.due) || ((a.due == b.due) && tl);
    end
    return ($signed(a.tag.prio) < $signed(b.tag.prio)) ||
           ((a.tag.prio == b.tag.prio) && tl);
  endfunction

  // a sorts strictly after b; a ticket gap of exactly half the range counts as older
  function automatic logic entry_after(logic which, entry_t a, entry_t b);
    logic [15:0] d;
    logic        tg;
    d = a.tag.ticket - b.tag.ticket;
    tg = (d != 16'd0) && !d[15];
    if (!which) begin
      return (a.due > b.due) || ((a.due == b.due) && tg);
    end
    return ($signed(a.tag.prio) > $signed(b.tag.prio)) ||
           ((a.tag.prio == b.tag.prio) && tg);
  endfunction

endpackage
`default_nettype wire

// ----- design/tpts_ram.sv -----
`default_nettype none
module tpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/timed_priority_task_scheduler.sv -----
// Task scheduler with two binary min-heaps held in single-port-read RAMs: a time
// heap (due time, then ticket) and a priority heap (priority, then ticket). Items
// are taken one at a time; s_tready is high only while the block is idle. A defer
// that fits sifts its new entry up the time heap; a cancel sweeps every stored
// entry of both heaps; a run does a sift-down for every task it moves or pops,
// plus an insert into the priority heap for each moved task. These walks are paced
// by the one read port of each heap RAM and its registered read data. Each item
// gives one result, except a run, which gives its dispatched tasks and then a
// summary; tlast marks the final result. A one-entry output register holds a
// result while the sink stalls.
// min_priority is written over the cfg channel while the block is idle.
`default_nettype none
module timed_priority_task_scheduler #(
  parameter int TIME_HEAP_DEPTH = 32,
  parameter int PRIO_HEAP_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: time_value[47:0], priority_req[63:48], task_id[79:64]
  input  wire logic [79:0] s_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: out_task_id[15:0], accepted[16], dispatched_count[22:17],
  // dropped_count[28:23], next_valid[29], next_time[77:30], zero fill [79:78]
  output logic [79:0]      m_tdata,
  // tuser: result_kind[1:0]
  output logic [1:0]       m_tuser,
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import tpts_pkg::*;

  localparam int TD   = TIME_HEAP_DEPTH;
  localparam int PD   = PRIO_HEAP_DEPTH;
  localparam int MAXD = (TD > PD) ? TD : PD;
  localparam int IW   = $clog2(MAXD);
  localparam int CW   = $clog2(MAXD + 1);
  localparam int NW   = IW + 2;
  localparam int TAW  = $clog2(TD);
  localparam int PAW  = $clog2(PD);
  localparam int TCW  = $clog2(TD + 1);
  localparam int PCW  = $clog2(PD + 1);

  state_t           state, state_next;
  state_t           ret;
  logic             which;
  logic [IW-1:0]    idx;
  entry_t           ent, kid, cur;
  entry_t           ttop;
  tag_t             ptop;
  logic [TCW-1:0]   tcount;
  logic [PCW-1:0]   pcount;
  logic [15:0]      ticket;
  logic [15:0]      min_prio;
  req_t             req;
  logic [47:0]      tv;
  logic [15:0]      req_id;
  logic             acc;
  logic [5:0]       disp, drop;
  result_t          res;

  // datapath next values
  state_t           ret_next;
  logic             which_next;
  logic [IW-1:0]    idx_next;
  entry_t           ent_next, kid_next, cur_next;
  logic [TCW-1:0]   tcount_next;
  logic [PCW-1:0]   pcount_next;
  logic [15:0]      ticket_next;
  logic             acc_next;
  logic [5:0]       disp_next, drop_next;

  logic             in_acc;
  logic             slot_free;
  logic             out_load;
  result_t          out_res;

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  entry_t           wr_data;
  logic [IW-1:0]    rd_addr;

  logic             t_we, p_we;
  logic [ENTRY_W-1:0] t_rdata;
  logic [TAG_W-1:0]   p_rdata;
  entry_t           rent;

  logic [CW-1:0]    n;
  logic [NW-1:0]    n_ext, lchild, rchild;
  logic [IW-1:0]    parent;
  logic             wake_now;
  logic             pick_r;
  logic             can_last;
  entry_t           chosen;
  logic [IW-1:0]    chosen_idx;

  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = (state == S_IDLE) && !rst;
  assign slot_free = !m_tvalid || m_tready;

  assign n      = which ? CW'(pcount) : CW'(tcount);
  assign n_ext  = NW'(n);
  assign lchild = NW'({idx, 1'b1});
  assign rchild = NW'({idx, 1'b1}) + NW'(1);
  assign parent = (idx - IW'(1)) >> 1;
  assign rent   = which ? entry_t'({48'd0, p_rdata}) : entry_t'(t_rdata);

  assign pick_r     = (rchild < n_ext) && entry_less(which, rent, kid);
  assign chosen     = pick_r ? rent : kid;
  assign chosen_idx = pick_r ? rchild[IW-1:0] : lchild[IW-1:0];

  // the entry being swept is the last one stored in this heap
  assign can_last = (NW'(idx) + NW'(1)) >= n_ext;

  assign wake_now = (pcount != '0) && ($signed(ptop.prio) <= $signed(min_prio));

  assign t_we = wr_en && !which;
  assign p_we = wr_en && which;

  tpts_ram #(.WIDTH(ENTRY_W), .DEPTH(TD)) u_time_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (wr_addr[TAW-1:0]),
    .wdata (wr_data),
    .raddr (rd_addr[TAW-1:0]),
    .rdata (t_rdata)
  );

  tpts_ram #(.WIDTH(TAG_W), .DEPTH(PD)) u_prio_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (wr_addr[PAW-1:0]),
    .wdata (wr_data.tag),
    .raddr (rd_addr[PAW-1:0]),
    .rdata (p_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_t'(s_tuser))
            REQ_DEFER_TIMED, REQ_DEFER_NOW:
              state_next = (tcount < TCW'(TD)) ? S_UP_CHK : S_ACK;
            REQ_CANCEL: state_next = S_CAN_RD;
            REQ_RUN:    state_next = S_RUN_T;
          endcase
        end
      end
      S_UP_CHK:   state_next = (idx == '0) ? ret : S_UP_CMP;
      S_UP_CMP:   state_next = entry_after(which, rent, ent) ? S_UP_CHK : ret;
      S_POP_LAST: state_next = (n == '0) ? ret : S_POP_GET;
      S_POP_GET:  state_next = S_DN_CHK;
      S_DN_CHK:   state_next = (lchild >= n_ext) ? ret : S_DN_RR;
      S_DN_RR:    state_next = S_DN_CMP;
      S_DN_CMP:   state_next = entry_after(which, ent, chosen) ? S_DN_CHK : ret;
      S_CAN_RD: begin
        if (NW'(idx) >= n_ext) begin
          state_next = which ? S_ACK : S_CAN_RD;
        end else begin
          state_next = S_CAN_WR;
        end
      end
      S_CAN_WR: state_next = (can_last && which) ? S_ACK : S_CAN_RD;
      S_RUN_T: begin
        state_next = ((tcount != '0) && (ttop.due < tv)) ? S_POP_LAST : S_RUN_P;
      end
      S_RUN_MV: begin
        state_next = (cur.tag.live && (pcount < PCW'(PD))) ? S_UP_CHK : S_RUN_T;
      end
      S_RUN_P: begin
        state_next = (wake_now && (disp < MAX_DISPATCH)) ? S_POP_LAST : S_SUM;
      end
      S_RUN_EM: begin
        if (!cur.tag.live || slot_free) state_next = S_RUN_P;
      end
      S_SUM, S_ACK: begin
        if (slot_free) state_next = S_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    ret_next    = ret;
    which_next  = which;
    idx_next    = idx;
    ent_next    = ent;
    kid_next    = kid;
    cur_next    = cur;
    tcount_next = tcount;
    pcount_next = pcount;
    ticket_next = ticket;
    acc_next    = acc;
    disp_next   = disp;
    drop_next   = drop;
    wr_en       = 1'b0;
    wr_addr     = idx;
    wr_data     = ent;
    rd_addr     = idx;
    out_load    = 1'b0;
    out_res     = '0;
    out_res.next_valid = wake_now || (tcount != '0);
    out_res.next_time  = wake_now ? 48'd0 : ((tcount != '0) ? ttop.due : 48'd0);
    out_res.id         = req_id;

    unique case (state)
      S_IDLE: begin
        if (in_acc && (s_tuser == REQ_DEFER_TIMED || s_tuser == REQ_DEFER_NOW)) begin
          ticket_next = ticket + 16'd1;
          ent_next.due = (s_tuser == REQ_DEFER_TIMED) ? s_tdata[47:0] : 48'd0;
          ent_next.tag = '{live: 1'b1, prio: s_tdata[63:48], ticket: ticket,
                           id: s_tdata[79:64]};
          which_next = 1'b0;
          ret_next   = S_ACK;
          if (tcount < TCW'(TD)) begin
            idx_next    = IW'(tcount);
            tcount_next = tcount + TCW'(1);
            acc_next    = 1'b1;
          end else begin
            acc_next = 1'b0;
          end
        end else if (in_acc) begin
          which_next = 1'b0;
          idx_next   = '0;
          acc_next   = 1'b0;
          disp_next  = '0;
          drop_next  = '0;
        end
      end
      S_UP_CHK: begin
        rd_addr = parent;
        if (idx == '0) wr_en = 1'b1;
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (entry_after(which, rent, ent)) begin
          wr_data  = rent;
          idx_next = parent;
        end
      end
      S_POP_LAST: begin
        rd_addr = n[IW-1:0];
      end
      S_POP_GET: begin
        ent_next = rent;
        idx_next = '0;
      end
      S_DN_CHK: begin
        rd_addr = lchild[IW-1:0];
        if (lchild >= n_ext) wr_en = 1'b1;
      end
      S_DN_RR: begin
        kid_next = rent;
        rd_addr  = rchild[IW-1:0];
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (entry_after(which, ent, chosen)) begin
          wr_data  = chosen;
          idx_next = chosen_idx;
        end
      end
      S_CAN_RD: begin
        if (NW'(idx) >= n_ext) begin
          which_next = 1'b1;
          idx_next   = '0;
        end
      end
      S_CAN_WR: begin
        wr_en   = 1'b1;
        wr_data = rent;
        if (rent.tag.id == req_id) wr_data.tag.live = 1'b0;
        if (can_last) begin
          which_next = 1'b1;
          idx_next   = '0;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_RUN_T: begin
        if ((tcount != '0) && (ttop.due < tv)) begin
          cur_next    = ttop;
          tcount_next = tcount - TCW'(1);
          which_next  = 1'b0;
          ret_next    = S_RUN_MV;
        end
      end
      S_RUN_MV: begin
        if (cur.tag.live) begin
          if (pcount < PCW'(PD)) begin
            ent_next    = cur;
            idx_next    = IW'(pcount);
            pcount_next = pcount + PCW'(1);
            which_next  = 1'b1;
            ret_next    = S_RUN_T;
          end else if (drop != DROP_SAT) begin
            drop_next = drop + 6'd1;
          end
        end
      end
      S_RUN_P: begin
        if (wake_now && (disp < MAX_DISPATCH)) begin
          cur_next     = '0;
          cur_next.tag = ptop;
          pcount_next  = pcount - PCW'(1);
          which_next   = 1'b1;
          ret_next     = S_RUN_EM;
        end
      end
      S_RUN_EM: begin
        if (cur.tag.live && slot_free) begin
          out_load        = 1'b1;
          out_res         = '0;
          out_res.kind    = KIND_DISPATCH;
          out_res.id      = cur.tag.id;
          disp_next       = disp + 6'd1;
        end
      end
      S_SUM: begin
        out_load           = slot_free;
        out_res.kind       = KIND_SUMMARY;
        out_res.id         = 16'd0;
        out_res.dispatched = disp;
        out_res.dropped    = drop;
      end
      S_ACK: begin
        out_load         = slot_free;
        out_res.kind     = (req == REQ_CANCEL) ? KIND_CANCEL_ACK : KIND_DEFER_ACK;
        out_res.accepted = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tcount   <= '0;
      pcount   <= '0;
      ticket   <= '0;
      min_prio <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      tcount <= tcount_next;
      pcount <= pcount_next;
      ticket <= ticket_next;
      if (cfg_valid && cfg_ready) min_prio <= cfg_data;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret   <= ret_next;
    which <= which_next;
    idx   <= idx_next;
    ent   <= ent_next;
    kid   <= kid_next;
    cur   <= cur_next;
    acc   <= acc_next;
    disp  <= disp_next;
    drop  <= drop_next;
    if (in_acc) begin
      req    <= req_t'(s_tuser);
      tv     <= s_tdata[47:0];
      req_id <= s_tdata[79:64];
    end
    if (out_load) res <= out_res;
    // mirrors of both heap tops for the wake report and the run checks
    if (t_we && wr_addr == '0) ttop <= wr_data;
    if (p_we && wr_addr == '0) ptop <= wr_data.tag;
  end

  assign m_tuser = res.kind;
  assign m_tlast = (res.kind != KIND_DISPATCH);
  assign m_tdata = {2'b00, res.next_time, res.next_valid, res.dropped, res.dispatched,
                    res.accepted, res.id};

  a_tcount_max: assert property (@(posedge clk) disable iff (rst)
    tcount <= TCW'(TD)) else $error("time heap count beyond depth");
  a_pcount_max: assert property (@(posedge clk) disable iff (rst)
    pcount <= PCW'(PD)) else $error("priority heap count beyond depth");
  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) < n)) else $error("heap write outside stored entries");
  a_disp_limit: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (disp <= MAX_DISPATCH)) else $error("dispatch limit exceeded");
  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser == REQ_RUN) |=> !s_tready) else $error("run accepted while busy");

endmodule
`default_nettype wire

// ----- dv/tb_timed_priority_task_scheduler.sv -----
`default_nettype none
module tb_timed_priority_task_scheduler;
  import tpts_pkg::*;

  localparam int TDEPTH = 32;
  localparam int PDEPTH = 32;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    req_t        req;
    logic [47:0] tv;
    logic [15:0] prio;
    logic [15:0] id;
  } sched_req_t;

  typedef struct {
    logic [1:0]  kind;
    logic        last;
    logic [79:0] data;
  } sched_res_t;

  class scoreboard;
    logic [47:0] tdue[TDEPTH];
    tag_t        ttag[TDEPTH];
    tag_t        ptag[PDEPTH];
    int          tcnt;
    int          pcnt;
    logic [15:0] ticket;
    logic [15:0] min_prio;
    sched_res_t  pending[$];
    int          errors;

    function new();
      tcnt = 0; pcnt = 0; ticket = 0; min_prio = 0; errors = 0;
    endfunction

    function void set_min_priority(logic [15:0] v);
      min_prio = v;
    endfunction

    function bit older(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return (d != 16'd0) && d[15];
    endfunction

    function bit newer(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return (d != 16'd0) && !d[15];
    endfunction

    function bit t_less(int a, int b);
      return (tdue[a] < tdue[b]) ||
             ((tdue[a] == tdue[b]) && older(ttag[a].ticket, ttag[b].ticket));
    endfunction

    function bit p_less(int a, int b);
      return ($signed(ptag[a].prio) < $signed(ptag[b].prio)) ||
             ((ptag[a].prio == ptag[b].prio) && older(ptag[a].ticket, ptag[b].ticket));
    endfunction

    function bit t_greater(int a, int b);
      return (tdue[a] > tdue[b]) ||
             ((tdue[a] == tdue[b]) && newer(ttag[a].ticket, ttag[b].ticket));
    endfunction

    function bit p_greater(int a, int b);
      return ($signed(ptag[a].prio) > $signed(ptag[b].prio)) ||
             ((ptag[a].prio == ptag[b].prio) && newer(ptag[a].ticket, ptag[b].ticket));
    endfunction

    function void swap_entries(bit pq, int a, int b);
      logic [47:0] d;
      tag_t        t;
      if (!pq) begin
        d = tdue[a]; tdue[a] = tdue[b]; tdue[b] = d;
        t = ttag[a]; ttag[a] = ttag[b]; ttag[b] = t;
      end else begin
        t = ptag[a]; ptag[a] = ptag[b]; ptag[b] = t;
      end
    endfunction

    function bit less(bit pq, int a, int b);
      return pq ? p_less(a, b) : t_less(a, b);
    endfunction

    function bit greater(bit pq, int a, int b);
      return pq ? p_greater(a, b) : t_greater(a, b);
    endfunction

    function void sift_up(bit pq, int c);
      int p;
      while (c > 0) begin
        p = (c - 1) / 2;
        if (!greater(pq, p, c)) break;
        swap_entries(pq, p, c);
        c = p;
      end
    endfunction

    function void pop_top(bit pq);
      int n, p, c, r;
      if (!pq) begin
        tcnt--; tdue[0] = tdue[tcnt]; ttag[0] = ttag[tcnt]; n = tcnt;
      end else begin
        pcnt--; ptag[0] = ptag[pcnt]; n = pcnt;
      end
      p = 0;
      c = 1;
      while (c < n) begin
        r = 2 * p + 2;
        if (r < n && less(pq, r, c)) c = r;
        if (!greater(pq, p, c)) break;
        swap_entries(pq, p, c);
        p = c;
        c = 2 * p + 1;
      end
    endfunction

    function void push_result(kind_t k, logic [15:0] id, logic acc, logic [5:0] disp,
                              logic [5:0] drop, bit with_wake, logic last);
      sched_res_t  e;
      logic        nv;
      logic [47:0] nt;
      nv = 0; nt = 0;
      if (with_wake) begin
        if (pcnt > 0 && $signed(ptag[0].prio) <= $signed(min_prio)) begin
          nv = 1;
        end else if (tcnt > 0) begin
          nv = 1; nt = tdue[0];
        end
      end
      e.kind = k;
      e.last = last;
      e.data = {2'b00, nt, nv, drop, disp, acc, id};
      pending.push_back(e);
    endfunction

    function void note_request(sched_req_t r);
      tag_t tg;
      int   disp, drop;
      case (r.req)
        REQ_DEFER_TIMED, REQ_DEFER_NOW: begin
          tg = '{live: 1'b1, prio: r.prio, ticket: ticket, id: r.id};
          ticket++;
          if (tcnt < TDEPTH) begin
            tdue[tcnt] = (r.req == REQ_DEFER_TIMED) ? r.tv : 48'd0;
            ttag[tcnt] = tg;
            tcnt++;
            sift_up(0, tcnt - 1);
            push_result(KIND_DEFER_ACK, r.id, 1'b1, 6'd0, 6'd0, 1, 1'b1);
          end else begin
            push_result(KIND_DEFER_ACK, r.id, 1'b0, 6'd0, 6'd0, 1, 1'b1);
          end
        end
        REQ_CANCEL: begin
          for (int i = 0; i < tcnt; i++) if (ttag[i].id == r.id) ttag[i].live = 1'b0;
          for (int i = 0; i < pcnt; i++) if (ptag[i].id == r.id) ptag[i].live = 1'b0;
          push_result(KIND_CANCEL_ACK, r.id, 1'b0, 6'd0, 6'd0, 1, 1'b1);
        end
        default: begin
          disp = 0;
          drop = 0;
          while (tcnt > 0 && tdue[0] < r.tv) begin
            tg = ttag[0];
            pop_top(0);
            if (!tg.live) continue;
            if (pcnt >= PDEPTH) begin
              if (drop < 63) drop++;
              continue;
            end
            ptag[pcnt] = tg;
            pcnt++;
            sift_up(1, pcnt - 1);
          end
          while (pcnt > 0 && disp < 32 && $signed(ptag[0].prio) <= $signed(min_prio)) begin
            tg = ptag[0];
            pop_top(1);
            if (tg.live) begin
              push_result(KIND_DISPATCH, tg.id, 1'b0, 6'd0, 6'd0, 0, 1'b0);
              disp++;
            end
          end
          push_result(KIND_SUMMARY, 16'd0, 1'b0, disp[5:0], drop[5:0], 1, 1'b1);
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [79:0] data, logic last);
      sched_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d last=%0b data=%h", $time, kind, last, data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.kind !== kind || e.last !== last || e.data !== data) begin
        $display("%0t: mismatch expected kind=%0d last=%0b data=%h, got kind=%0d last=%0b data=%h",
                 $time, e.kind, e.last, e.data, kind, last, data);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  scoreboard sb = new();
  int        send_idle_pct;
  int        recv_idle_pct;
  int        quiet_cycles;
  logic [47:0] now;

  timed_priority_task_scheduler #(
    .TIME_HEAP_DEPTH(TDEPTH),
    .PRIO_HEAP_DEPTH(PDEPTH)
  ) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(req_t req, logic [47:0] tv, logic [15:0] prio, logic [15:0] id);
    sched_req_t r;
    r = '{req: req, tv: tv, prio: prio, id: id};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid = 0;
    end
    @(negedge clk);
    s_tvalid = 1;
    s_tuser = req;
    s_tdata = {id, prio, tv};
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // block goes idle when its last result enters the output register, before it is out; a short margin follows
  task automatic write_min_priority(logic [15:0] v);
    wait_drained();
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_min_priority(v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_request();
    int          r;
    logic [47:0] tv;
    logic [15:0] prio, id;
    r = $urandom_range(0, 99);
    prio = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20) - 10);
    id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    if ($urandom_range(0, 15) == 0) tv = {16'($urandom), 32'($urandom)};
    else tv = now + $urandom_range(0, 300);
    if (r < 45) begin
      send_request(REQ_DEFER_TIMED, tv, prio, id);
    end else if (r < 55) begin
      send_request(REQ_DEFER_NOW, {16'($urandom), 32'($urandom)}, prio, id);
    end else if (r < 70) begin
      send_request(REQ_CANCEL, {16'($urandom), 32'($urandom)}, 16'($urandom), id);
    end else begin
      if ($urandom_range(0, 19) == 0) now = tv;
      else now = now + $urandom_range(0, 200);
      send_request(REQ_RUN, now, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] phase_min[4];
    rst = 1;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    m_tready = 0;
    cfg_valid = 0; cfg_data = '0;
    send_idle_pct = 22; recv_idle_pct = 47;
    quiet_cycles = 0;
    now = 48'd1000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: field extremes, immediate defer, dead tasks, runs at the time extremes
    send_request(REQ_DEFER_TIMED, 48'd0, 16'h8000, 16'h0000);
    send_request(REQ_DEFER_TIMED, TIME_MAX, 16'h7FFF, 16'hFFFF);
    send_request(REQ_DEFER_NOW, TIME_MAX, 16'h0005, 16'h1234);
    send_request(REQ_DEFER_NOW, 48'd0, 16'hFFFF, 16'h00AA);
    send_request(REQ_CANCEL, 48'd0, 16'h0000, 16'h1234);
    send_request(REQ_RUN, 48'd0, 16'h0000, 16'h0000);
    send_request(REQ_RUN, 48'd1, 16'hFFFF, 16'hFFFF);
    send_request(REQ_CANCEL, TIME_MAX, 16'hFFFF, 16'hBEEF);
    send_request(REQ_DEFER_TIMED, 48'd50, 16'h0001, 16'h0042);
    send_request(REQ_CANCEL, 48'd0, 16'h0000, 16'h0042);
    send_request(REQ_RUN, 48'd60, 16'h0000, 16'h0000);
    send_request(REQ_RUN, TIME_MAX, 16'h0000, 16'h0000);
    send_request(REQ_DEFER_TIMED, 48'h5555_5555_5555, 16'h5555, 16'h5555);
    send_request(REQ_DEFER_TIMED, 48'hAAAA_AAAA_AAAA, 16'hAAAA, 16'hAAAA);
    send_request(REQ_RUN, TIME_MAX, 16'h0000, 16'h0000);

    phase_min[0] = 16'h8000;
    phase_min[1] = 16'h7FFF;
    phase_min[2] = 16'($urandom);
    phase_min[3] = 16'h0000;
    for (int ph = 0; ph < 4; ph++) begin
      write_min_priority(phase_min[ph]);
      case (ph)
        0: begin send_idle_pct = 22; recv_idle_pct = 47; end
        1: begin send_idle_pct = 47; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 0) begin
        // overfill the time heap, park everything in the priority heap, then overflow it
        for (int i = 0; i < 36; i++)
          send_request(REQ_DEFER_TIMED, 48'(i), 16'($urandom_range(1, 32767)), 16'(i));
        send_request(REQ_RUN, TIME_MAX, 16'h0000, 16'h0000);
        for (int i = 0; i < 34; i++)
          send_request(REQ_DEFER_NOW, 48'd0, 16'($urandom_range(1, 500)), 16'(100 + i));
        send_request(REQ_CANCEL, 48'd0, 16'h0000, 16'd101);
        send_request(REQ_RUN, 48'd1, 16'h0000, 16'h0000);
        for (int i = 0; i < 39; i++) random_request();
      end else begin
        for (int i = 0; i < 80; i++) random_request();
        send_request(REQ_RUN, TIME_MAX, 16'h0000, 16'h0000);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
